// ----- rtl/core/tmid_pkg.sv -----
// Shared types, constants and saturating helpers for the triclinic minimum-image unit.
`default_nettype none
package tmid_pkg;

	localparam int COORD_W    = 32;
	localparam int DIV_BITS   = 2;
	localparam int DIV_STAGES = 64 / DIV_BITS;

	typedef logic signed [63:0] s64_t;
	typedef logic [2:0][63:0]   vec_t;

	typedef enum logic [2:0] {
		REG_BOX_XX = 3'd0,
		REG_BOX_YY = 3'd1,
		REG_BOX_ZZ = 3'd2,
		REG_BOX_YX = 3'd3,
		REG_BOX_ZX = 3'd4,
		REG_BOX_ZY = 3'd5
	} cfg_reg_t;

	localparam s64_t S64_MIN = {1'b1, 63'b0};
	localparam s64_t S64_MAX = {1'b0, {63{1'b1}}};

	function automatic logic [63:0] mag64(input logic [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	function automatic s64_t signed_sat(input logic neg, input logic [95:0] mag);
		s64_t r;
		if (neg) begin
			if (mag >= {32'b0, 1'b1, 63'b0}) r = S64_MIN;
			else r = s64_t'(64'd0 - mag[63:0]);
		end else begin
			if (mag > {33'b0, {63{1'b1}}}) r = S64_MAX;
			else r = s64_t'(mag[63:0]);
		end
		return r;
	endfunction

	function automatic s64_t sat_sub64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] r;
		s64_t        res;
		r = {a[63], a} - {b[63], b};
		if (r[64] != r[63]) res = r[64] ? S64_MIN : S64_MAX;
		else res = s64_t'(r[63:0]);
		return res;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/tmid_rdiv.sv -----
// Pipelined rounding divider: n = round(dividend / len), half away from zero, zero for len 0.
`default_nettype none
module tmid_rdiv (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire logic            in_valid,
	input  wire logic [63:0]     in_dvd,
	input  wire logic [30:0]     len,
	input  wire tmid_pkg::vec_t  in_vec,
	output logic                 out_valid,
	output tmid_pkg::s64_t       out_n,
	output tmid_pkg::vec_t       out_vec
);
	import tmid_pkg::*;

	logic [DIV_STAGES:0] vld_s;
	logic                neg_s [0:DIV_STAGES];
	logic [63:0]         mag_s [0:DIV_STAGES];
	logic [30:0]         rem_s [0:DIV_STAGES];
	logic [63:0]         q_s   [0:DIV_STAGES];
	vec_t                vec_s [0:DIV_STAGES];

	logic [63:0] q_rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s[0] <= in_dvd[63];
			mag_s[0] <= mag64(in_dvd);
			rem_s[0] <= '0;
			q_s[0]   <= '0;
			vec_s[0] <= in_vec;
		end
	end

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_it
		logic [63:0] nmag;
		logic [30:0] nrem;
		logic [63:0] nq;

		always_comb begin
			logic [31:0] t;
			nmag = mag_s[i];
			nrem = rem_s[i];
			nq   = q_s[i];
			for (int k = 0; k < DIV_BITS; k++) begin
				t    = {nrem, nmag[63]};
				nmag = {nmag[62:0], 1'b0};
				if (t >= {1'b0, len}) begin
					nrem = 31'(t - {1'b0, len});
					nq   = {nq[62:0], 1'b1};
				end else begin
					nrem = t[30:0];
					nq   = {nq[62:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				neg_s[i+1] <= neg_s[i];
				mag_s[i+1] <= nmag;
				rem_s[i+1] <= nrem;
				q_s[i+1]   <= nq;
				vec_s[i+1] <= vec_s[i];
			end
		end
	end

	assign q_rnd = q_s[DIV_STAGES] +
		64'(({rem_s[DIV_STAGES], 1'b0} >= {1'b0, len}) ? 1'b1 : 1'b0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_s[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_n   <= (len == '0) ? s64_t'(0) : signed_sat(neg_s[DIV_STAGES], {32'b0, q_rnd});
			out_vec <= vec_s[DIV_STAGES];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/tmid_wrap.sv -----
// Three-stage image shift: each component loses n times its box term, with saturation.
`default_nettype none
module tmid_wrap (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire logic                in_valid,
	input  wire tmid_pkg::s64_t      in_n,
	input  wire tmid_pkg::vec_t      in_vec,
	input  wire logic signed [31:0]  mul_x,
	input  wire logic signed [31:0]  mul_y,
	input  wire logic signed [31:0]  mul_z,
	output logic                     out_valid,
	output tmid_pkg::vec_t           out_vec
);
	import tmid_pkg::*;

	logic [31:0] mm [3];
	logic [2:0]  msg;
	logic [63:0] nmag;

	logic        vld_s1, vld_s2;
	logic [2:0]  neg_s1;
	logic [63:0] lo_s1 [3];
	logic [63:0] hi_s1 [3];
	vec_t        vec_s1, vec_s2;
	s64_t        prod_s2 [3];

	assign msg   = {mul_z[31], mul_y[31], mul_x[31]};
	assign mm[0] = 32'(mag64(64'(mul_x)));
	assign mm[1] = 32'(mag64(64'(mul_y)));
	assign mm[2] = 32'(mag64(64'(mul_z)));
	assign nmag  = mag64(in_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			out_valid <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				neg_s1[c]  <= msg[c] ^ in_n[63];
				lo_s1[c]   <= mm[c] * nmag[31:0];
				hi_s1[c]   <= mm[c] * nmag[63:32];
				prod_s2[c] <= signed_sat(neg_s1[c], {32'b0, lo_s1[c]} + {hi_s1[c], 32'b0});
				out_vec[c] <= sat_sub64(vec_s2[c], prod_s2[c]);
			end
			vec_s1 <= in_vec;
			vec_s2 <= vec_s1;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/tmid_sq.sv -----
// Two-stage saturating sum of squares of the wrapped vector.
`default_nettype none
module tmid_sq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           adv,
	input  wire logic           in_valid,
	input  wire tmid_pkg::vec_t in_vec,
	output logic                out_valid,
	output logic [63:0]         out_dist
);
	import tmid_pkg::*;

	logic        vld_s1;
	logic [2:0]  big_s1;
	logic [63:0] sq_s1 [3];
	logic [63:0] vm [3];
	logic [65:0] sum;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			vm[c] = mag64(in_vec[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_s1    <= in_valid;
			out_valid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				big_s1[c] <= |vm[c][63:32];
				sq_s1[c]  <= vm[c][31:0] * vm[c][31:0];
			end
		end
	end

	assign sum = 66'(sq_s1[0]) + 66'(sq_s1[1]) + 66'(sq_s1[2]);

	always_ff @(posedge clk) begin
		if (adv) begin
			out_dist <= ((|big_s1) || (|sum[65:64])) ? {64{1'b1}} : sum[63:0];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/triclinic_min_image_dist2_unit.sv -----
// Top level of the triclinic minimum-image squared-distance unit.
//
//  Channel   Signals                                Content (low bit first)
//  s_axis    tvalid tready tdata[191:0]             ax ay az bx by bz, 32 bits each
//  m_axis    tvalid tready tdata[63:0]              dist_sq, unsigned Q32.32
//  cfg       cfg_valid cfg_ready cfg_index cfg_data box register write
//
//  One pair per cycle while the result is not stalled; the three rounding dividers have 34 stages each.
//  All stages advance together; a stalled result freezes the whole pipeline in place.
//  Reset clears the valid bits and loads the unit box; configuration writes take effect
//  at once and are accepted in every cycle.
`default_nettype none
module triclinic_min_image_dist2_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [191:0] s_axis_tdata,  // ax, ay, az, bx, by, bz
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [63:0]       m_axis_tdata,  // dist_sq
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);
	import tmid_pkg::*;

	logic [30:0]        box_xx_q, box_yy_q, box_zz_q;
	logic signed [31:0] box_yx_q, box_zx_q, box_zy_q;

	logic adv;
	logic vld_s1;
	vec_t vec_s1;
	vec_t diff;

	logic zd_v, zw_v, yd_v, yw_v, xd_v, xw_v;
	s64_t zd_n, yd_n, xd_n;
	vec_t zd_vec, zw_vec, yd_vec, yw_vec, xd_vec, xw_vec;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_xx_q <= 31'd65536;
			box_yy_q <= 31'd65536;
			box_zz_q <= 31'd65536;
			box_yx_q <= '0;
			box_zx_q <= '0;
			box_zy_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_BOX_XX: box_xx_q <= cfg_data[30:0];
				REG_BOX_YY: box_yy_q <= cfg_data[30:0];
				REG_BOX_ZZ: box_zz_q <= cfg_data[30:0];
				REG_BOX_YX: box_yx_q <= cfg_data;
				REG_BOX_ZX: box_zx_q <= cfg_data;
				REG_BOX_ZY: box_zy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	for (genvar c = 0; c < 3; c++) begin : g_diff
		assign diff[c] =
			64'(signed'(s_axis_tdata[32*c +: COORD_W])) -
			64'(signed'(s_axis_tdata[32*(c+3) +: COORD_W]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vec_s1 <= diff;
		end
	end

	tmid_rdiv u_div_z (
		.clk, .arst_n, .adv,
		.in_valid (vld_s1), .in_dvd (vec_s1[2]), .len (box_zz_q), .in_vec (vec_s1),
		.out_valid (zd_v), .out_n (zd_n), .out_vec (zd_vec)
	);

	tmid_wrap u_wrap_z (
		.clk, .arst_n, .adv,
		.in_valid (zd_v), .in_n (zd_n), .in_vec (zd_vec),
		.mul_x (box_zx_q), .mul_y (box_zy_q), .mul_z ({1'b0, box_zz_q}),
		.out_valid (zw_v), .out_vec (zw_vec)
	);

	tmid_rdiv u_div_y (
		.clk, .arst_n, .adv,
		.in_valid (zw_v), .in_dvd (zw_vec[1]), .len (box_yy_q), .in_vec (zw_vec),
		.out_valid (yd_v), .out_n (yd_n), .out_vec (yd_vec)
	);

	tmid_wrap u_wrap_y (
		.clk, .arst_n, .adv,
		.in_valid (yd_v), .in_n (yd_n), .in_vec (yd_vec),
		.mul_x (box_yx_q), .mul_y ({1'b0, box_yy_q}), .mul_z (32'sd0),
		.out_valid (yw_v), .out_vec (yw_vec)
	);

	tmid_rdiv u_div_x (
		.clk, .arst_n, .adv,
		.in_valid (yw_v), .in_dvd (yw_vec[0]), .len (box_xx_q), .in_vec (yw_vec),
		.out_valid (xd_v), .out_n (xd_n), .out_vec (xd_vec)
	);

	tmid_wrap u_wrap_x (
		.clk, .arst_n, .adv,
		.in_valid (xd_v), .in_n (xd_n), .in_vec (xd_vec),
		.mul_x ({1'b0, box_xx_q}), .mul_y (32'sd0), .mul_z (32'sd0),
		.out_valid (xw_v), .out_vec (xw_vec)
	);

	tmid_sq u_sq (
		.clk, .arst_n, .adv,
		.in_valid (xw_v), .in_vec (xw_vec),
		.out_valid (m_axis_tvalid), .out_dist (m_axis_tdata)
	);

endmodule
`default_nettype wire

// ----- rtl/core/tmid_check.sv -----
// Port-level checker for the triclinic minimum-image unit, bound to the top level.
`default_nettype none
module tmid_check (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [63:0]  m_axis_tdata,
	input wire logic         cfg_valid,
	input wire logic         cfg_ready
);

	// An empty output stage never holds back the input side.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while no result is pending");

	// A stalled result keeps the whole pipeline frozen.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("input accepted while the result is stalled");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");

	a_cfg_always_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration transfer refused");

endmodule

bind triclinic_min_image_dist2_unit tmid_check u_tmid_check (.*);
`default_nettype wire

// ----- tb/triclinic_min_image_dist2_checker.sv -----
// Checker that predicts and compares squared minimum-image distances for the unit.
`default_nettype none
module triclinic_min_image_dist2_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	input  wire logic         s_axis_tready,
	input  wire logic [191:0] s_axis_tdata,
	input  wire logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	input  wire logic [63:0]  m_axis_tdata,
	input  wire logic         cfg_valid,
	input  wire logic         cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	output int                failures,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import tmid_pkg::*;

	logic [63:0] len_x, len_y, len_z;
	s64_t        tilt_yx, tilt_zx, tilt_zy;
	logic [63:0] dist_queue[$];

	function automatic logic [63:0] magnitude(input s64_t v);
		return v < 0 ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	function automatic s64_t clamp_signed(input logic neg, input logic [63:0] m);
		if (neg) return (m >= {1'b1, 63'b0}) ? S64_MIN : -s64_t'(m);
		return (m > {1'b0, {63{1'b1}}}) ? S64_MAX : s64_t'(m);
	endfunction

	function automatic s64_t clamp_sub(input s64_t a, input s64_t b);
		logic signed [64:0] r;
		r = 65'(a) - 65'(b);
		if (r > 65'(S64_MAX)) return S64_MAX;
		if (r < 65'(S64_MIN)) return S64_MIN;
		return s64_t'(r);
	endfunction

	function automatic s64_t clamp_mul(input s64_t a, input s64_t b);
		logic [127:0] p;
		p = 128'(magnitude(a)) * 128'(magnitude(b));
		return clamp_signed((a < 0) != (b < 0), p[127:64] != 0 ? '1 : p[63:0]);
	endfunction

	function automatic s64_t nearest_images(input s64_t d, input logic [63:0] len);
		logic [63:0] m, q, r;
		if (len == 0) return 0;
		m = magnitude(d);
		q = m / len;
		r = m % len;
		if (r >= len - r) q++;
		return clamp_signed(d < 0, q);
	endfunction

	function automatic logic [63:0] square_clamped(input s64_t v);
		logic [63:0] m;
		m = magnitude(v);
		return m > 64'hFFFF_FFFF ? '1 : m * m;
	endfunction

	function automatic logic [63:0] add_clamped(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = 65'(a) + 65'(b);
		return s[64] ? '1 : s[63:0];
	endfunction

	function automatic logic [63:0] min_image_dist2(input logic [191:0] p);
		s64_t dx, dy, dz, n;
		dx = s64_t'($signed(p[31:0])) - s64_t'($signed(p[127:96]));
		dy = s64_t'($signed(p[63:32])) - s64_t'($signed(p[159:128]));
		dz = s64_t'($signed(p[95:64])) - s64_t'($signed(p[191:160]));
		n = nearest_images(dz, len_z);
		dz = clamp_sub(dz, clamp_mul(s64_t'(len_z), n));
		dy = clamp_sub(dy, clamp_mul(tilt_zy, n));
		dx = clamp_sub(dx, clamp_mul(tilt_zx, n));
		n = nearest_images(dy, len_y);
		dy = clamp_sub(dy, clamp_mul(s64_t'(len_y), n));
		dx = clamp_sub(dx, clamp_mul(tilt_yx, n));
		n = nearest_images(dx, len_x);
		dx = clamp_sub(dx, clamp_mul(s64_t'(len_x), n));
		return add_clamped(add_clamped(square_clamped(dx), square_clamped(dy)),
			square_clamped(dz));
	endfunction

	assign pending = dist_queue.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_x <= 64'd65536;
			len_y <= 64'd65536;
			len_z <= 64'd65536;
			tilt_yx <= 0;
			tilt_zx <= 0;
			tilt_zy <= 0;
			failures <= 0;
			dist_queue.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				dist_queue.push_back(min_image_dist2(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (dist_queue.size() == 0) begin
					$display("%0t: unexpected transfer, actual %h", $time, m_axis_tdata);
					failures <= failures + 1;
				end else begin
					if (dist_queue[0] !== m_axis_tdata) begin
						$display("%0t: dist_sq expected %h actual %h", $time,
							dist_queue[0], m_axis_tdata);
						failures <= failures + 1;
					end
					void'(dist_queue.pop_front());
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_BOX_XX: len_x <= {33'd0, cfg_data[30:0]};
					REG_BOX_YY: len_y <= {33'd0, cfg_data[30:0]};
					REG_BOX_ZZ: len_z <= {33'd0, cfg_data[30:0]};
					REG_BOX_YX: tilt_yx <= s64_t'($signed(cfg_data));
					REG_BOX_ZX: tilt_zx <= s64_t'($signed(cfg_data));
					REG_BOX_ZY: tilt_zy <= s64_t'($signed(cfg_data));
					default: ;
				endcase
			end
		end
	end
endmodule
`default_nettype wire

// ----- tb/triclinic_min_image_dist2_unit_test.sv -----
// Stimulus and verdict for the triclinic minimum-image squared-distance unit.
`default_nettype none
module triclinic_min_image_dist2_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import tmid_pkg::*;

	localparam int QUIET_LIMIT = 20000;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [191:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [63:0]  m_axis_tdata;
	logic         cfg_valid = 0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = '0;
	logic [31:0]  cfg_data = '0;
	int           failures, pending, quiet_cycles = 0;

	triclinic_min_image_dist2_unit dut (.*);
	triclinic_min_image_dist2_checker checker_i (.*);

	always #1 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	int drain_mode = 0;
	always @(posedge clk) begin
		if (drain_mode == 1) m_axis_tready <= 1'b1;
		else if (drain_mode == 2) m_axis_tready <= ($urandom_range(0, 3) != 0);
		else if ($urandom_range(0, 19) == 0) m_axis_tready <= 1'b0;
		else if ($urandom_range(0, 9) == 0) m_axis_tready <= 1'b1;
		else m_axis_tready <= m_axis_tready ? ($urandom_range(0, 6) != 0)
			: ($urandom_range(0, 2) == 0);
	end
	always @(posedge clk) if ($urandom_range(0, 299) == 0) drain_mode <= $urandom_range(0, 2);

	// The valid stays high after a transfer so that the next item can follow at once;
	// a gap or a drain lowers it.
	task automatic send_pair(input logic [191:0] p, input bit gaps);
		int g;
		g = gaps ? pick_gap() : 0;
		if (g != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= p;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic write_box(input cfg_reg_t idx, input logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (130) @(posedge clk);
	endtask

	task automatic load_box(input logic [31:0] xx, yy, zz, yx, zx, zy);
		wait_drained();
		write_box(REG_BOX_XX, xx);
		write_box(REG_BOX_YY, yy);
		write_box(REG_BOX_ZZ, zz);
		write_box(REG_BOX_YX, yx);
		write_box(REG_BOX_ZX, zx);
		write_box(REG_BOX_ZY, zy);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_coord(input logic [31:0] span);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 32'h8000_0000;
		if (r == 1) return 32'h7FFF_FFFF;
		if (r < 4) return $urandom();
		return $urandom_range(0, 32'(span) * 3) - 32'(span) * 3 / 2;
	endfunction

	function automatic logic [191:0] rand_pair(input logic [31:0] span);
		logic [191:0] p;
		for (int k = 0; k < 6; k++) p[k*32 +: 32] = rand_coord(span);
		return p;
	endfunction

	function automatic logic [31:0] rand_len();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 32'h7FFF_FFFF;
		if (r == 1) return 32'd1;
		if (r == 2) return 32'd0;
		if (r < 5) return $urandom() & 32'h7FFF_FFFF;
		return $urandom_range(1, 32'h0010_0000);
	endfunction

	function automatic logic [31:0] rand_tilt();
		int r;
		r = $urandom_range(0, 6);
		if (r == 0) return 32'h8000_0000;
		if (r == 1) return 32'h7FFF_FFFF;
		if (r < 4) return $urandom();
		return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
	endfunction

	initial begin
		logic [31:0] lx;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Unit box, extreme coordinates and exact halves.
		send_pair('0, 0);
		send_pair({32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 0);
		send_pair({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 0);
		send_pair({96'd0, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000}, 0);
		send_pair({96'd0, 32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000}, 0);
		send_pair({96'd0, 32'h0001_8000, 32'h0002_8000, 32'hFFFE_8000}, 0);
		load_box(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		send_pair({32'h8000_0000, 64'd0, 32'h7FFF_FFFF, 64'd0}, 0);
		send_pair({96'h8000_0000_8000_0000_8000_0000, 96'h7FFF_FFFF_7FFF_FFFF_7FFF_FFFF}, 0);
		send_pair({96'd0, 32'h1234_5678, 32'hFEDC_BA98, 32'h0000_0001}, 0);
		load_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		send_pair({96'h8000_0000_8000_0000_8000_0000, 96'h7FFF_FFFF_7FFF_FFFF_7FFF_FFFF}, 0);
		send_pair({96'h7FFF_FFFF_7FFF_FFFF_7FFF_FFFF, 96'h8000_0000_8000_0000_8000_0000}, 0);
		send_pair({96'd0, 32'hC000_0000, 32'h4000_0000, 32'hBFFF_FFFF}, 0);
		load_box(32'd1, 32'd1, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
		send_pair({96'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001}, 0);
		send_pair({96'd5, 96'h3}, 0);
		load_box(32'h0003_0000, 32'h0002_0000, 32'h0004_0000,
			32'h0000_8000, 32'hFFFF_0000, 32'h0001_4000);
		send_pair({96'd0, 32'h0001_8000, 32'h0001_0000, 32'h0002_0000}, 0);
		send_pair({96'd0, 32'hFFFE_8000, 32'hFFFF_0000, 32'hFFFE_0000}, 0);
		send_pair({96'd0, 32'h000A_1234, 32'hFFF3_0000, 32'h0017_FFFF}, 0);
		// Random boxes with random pairs; at least one pause until all results are in.
		for (int ph = 0; ph < 16; ph++) begin
			lx = rand_len();
			load_box(lx, rand_len(), rand_len(), rand_tilt(), rand_tilt(), rand_tilt());
			for (int i = 0; i < 50; i++) begin
				send_pair(rand_pair(lx == 0 ? 32'h0010_0000 : lx), ph % 3 != 0);
				if (i == 25 && ph % 4 == 1) wait_drained();
			end
		end
		wait_drained();
		if (failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire
